// File: rtl/core/pwmc_pkg.sv
package pwmc_pkg;

    // tick counter width default
    localparam int COUNT_WIDTH_DEF = 32;

    // fixed field widths
    localparam int RATE_W    = 32;
    localparam int TIMEOUT_W = 32;
    localparam int DUTY_W    = 8;
    localparam int CFG_W     = 32;

    // shared divider schedule: frequency quotient bits, then duty bits
    localparam int FREQ_STEPS = RATE_W;
    localparam int DUTY_STEPS = DUTY_W;
    localparam int STEP_W     = $clog2(FREQ_STEPS + DUTY_STEPS);

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // configuration register indexes
    localparam logic CFG_TICK_RATE = 1'b0;
    localparam logic CFG_TIMEOUT   = 1'b1;

    // control part of one queued item
    typedef struct packed {
        logic is_clear;
        logic timed_out;
    } pwmc_ctl_t;

endpackage

// File: rtl/core/pwmc_fifo.sv
module pwmc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/pwmc_front.sv
module pwmc_front #(
    parameter int COUNT_WIDTH = pwmc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             operation,
    input  logic                             pin_level,
    input  logic [pwmc_pkg::TIMEOUT_W-1:0]   timeout_ticks,
    output logic                             q_push,
    output pwmc_pkg::pwmc_ctl_t              q_ctl,
    output logic [COUNT_WIDTH-1:0]           q_high,
    output logic [COUNT_WIDTH-1:0]           q_period
);
    import pwmc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HIGH,
        PH_LOW
    } phase_t;

    phase_t                 phase_reg,   phase_next;
    logic [COUNT_WIDTH-1:0] high_reg,    high_next;
    logic [COUNT_WIDTH-1:0] period_reg,  period_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic                   stopped_reg, stopped_next;

    logic [COUNT_WIDTH-1:0] high_inc;
    logic [COUNT_WIDTH-1:0] period_inc;
    logic [COUNT_WIDTH-1:0] elapsed_inc;
    logic                   done;

    // saturating counters
    assign high_inc    = (high_reg == '1) ? high_reg : high_reg + 1'b1;
    assign period_inc  = (period_reg == '1) ? period_reg : period_reg + 1'b1;
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;

    assign done = (timeout_ticks != '0) && (CMP_W'(elapsed_inc) > CMP_W'(timeout_ticks));

    assign q_high   = high_reg;
    assign q_period = period_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        high_next    = high_reg;
        period_next  = period_reg;
        elapsed_next = elapsed_reg;
        stopped_next = stopped_reg;
        q_push       = 1'b0;
        q_ctl        = '0;
        if (in_valid)
        begin
            if (operation == OP_CLEAR)
            begin
                q_push         = 1'b1;
                q_ctl.is_clear = 1'b1;
            end
            else if (!stopped_reg)
            begin
                elapsed_next = elapsed_inc;
                unique case (phase_reg)
                    PH_WAIT:
                    begin
                        if (pin_level)
                        begin
                            phase_next  = PH_HIGH;
                            high_next   = COUNT_WIDTH'(1);
                            period_next = COUNT_WIDTH'(1);
                        end
                    end
                    PH_HIGH:
                    begin
                        if (pin_level)
                        begin
                            high_next = high_inc;
                        end
                        else
                        begin
                            phase_next = PH_LOW;
                        end
                        period_next = period_inc;
                    end
                    PH_LOW:
                    begin
                        if (!pin_level)
                        begin
                            period_next = period_inc;
                        end
                        else
                        begin
                            // rising edge closes the cycle
                            q_push          = 1'b1;
                            q_ctl.timed_out = done;
                            phase_next      = PH_HIGH;
                            high_next       = COUNT_WIDTH'(1);
                            period_next     = COUNT_WIDTH'(1);
                            stopped_next    = done;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            high_reg    <= '0;
            period_reg  <= '0;
            elapsed_reg <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            high_reg    <= high_next;
            period_reg  <= period_next;
            elapsed_reg <= elapsed_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// File: rtl/core/pwmc_back.sv
module pwmc_back #(
    parameter int COUNT_WIDTH = pwmc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [pwmc_pkg::RATE_W-1:0]    tick_rate_hz,
    input  logic                           q_empty,
    input  pwmc_pkg::pwmc_ctl_t            q_ctl,
    input  logic [COUNT_WIDTH-1:0]         q_high,
    input  logic [COUNT_WIDTH-1:0]         q_period,
    output logic                           q_pop,
    input  logic                           out_pop,
    output logic                           out_valid,
    output logic [pwmc_pkg::RATE_W-1:0]    out_frequency,
    output logic [pwmc_pkg::DUTY_W-1:0]    out_duty,
    output logic                           out_timed_out
);
    import pwmc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

    localparam logic [STEP_W-1:0] LAST_FREQ = STEP_W'(FREQ_STEPS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FREQ_STEPS + DUTY_STEPS - 1);

    state_t                 state_reg,  state_next;
    logic [STEP_W-1:0]      cnt_reg,    cnt_next;
    logic [RATE_W-1:0]      dvd_reg,    dvd_next;
    logic [COUNT_WIDTH-1:0] rem_reg,    rem_next;
    logic [COUNT_WIDTH-1:0] div_reg,    div_next;
    logic [COUNT_WIDTH-1:0] high_reg,   high_next;
    logic [RATE_W-1:0]      quo_reg,    quo_next;
    logic [DUTY_W-1:0]      dq_reg,     dq_next;
    logic                   dfull_reg,  dfull_next;
    logic                   done_reg,   done_next;
    logic [RATE_W-1:0]      favg_reg,   favg_next;
    logic [DUTY_W-1:0]      davg_reg,   davg_next;
    logic                   ovalid_reg, ovalid_next;
    logic [RATE_W-1:0]      ofreq_reg,  ofreq_next;
    logic [DUTY_W-1:0]      oduty_reg,  oduty_next;
    logic                   oto_reg,    oto_next;

    logic [COUNT_WIDTH:0]   r2;
    logic [COUNT_WIDTH:0]   diff;
    logic                   ge;
    logic [COUNT_WIDTH-1:0] rem_step;
    logic                   in_freq;
    logic [DUTY_W-1:0]      dnew;
    logic [RATE_W:0]        fsum;
    logic [DUTY_W:0]        dsum;

    // one restoring division step per cycle
    assign in_freq  = (cnt_reg <= LAST_FREQ);
    assign r2       = {rem_reg, in_freq ? dvd_reg[RATE_W-1] : 1'b0};
    assign diff     = r2 - {1'b0, div_reg};
    assign ge       = (r2 >= {1'b0, div_reg});
    assign rem_step = ge ? diff[COUNT_WIDTH-1:0] : r2[COUNT_WIDTH-1:0];

    assign dnew = dfull_reg ? '1 : dq_reg;
    assign fsum = {1'b0, favg_reg} + {1'b0, quo_reg};
    assign dsum = {1'b0, davg_reg} + {1'b0, dnew};

    assign out_valid     = ovalid_reg;
    assign out_frequency = ofreq_reg;
    assign out_duty      = oduty_reg;
    assign out_timed_out = oto_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        high_next   = high_reg;
        quo_next    = quo_reg;
        dq_next     = dq_reg;
        dfull_next  = dfull_reg;
        done_next   = done_reg;
        favg_next   = favg_reg;
        davg_next   = davg_reg;
        ovalid_next = ovalid_reg && !out_pop;
        ofreq_next  = ofreq_reg;
        oduty_next  = oduty_reg;
        oto_next    = oto_reg;
        q_pop       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_ctl.is_clear)
                    begin
                        favg_next = '0;
                        davg_next = '0;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        dvd_next   = tick_rate_hz;
                        rem_next   = '0;
                        div_next   = q_period;
                        high_next  = q_high;
                        dfull_next = (q_high >= q_period);
                        done_next  = q_ctl.timed_out;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (in_freq)
                begin
                    quo_next = {quo_reg[RATE_W-2:0], ge};
                    dvd_next = {dvd_reg[RATE_W-2:0], 1'b0};
                    // duty division starts from the high count
                    rem_next = (cnt_reg == LAST_FREQ) ? high_reg : rem_step;
                end
                else
                begin
                    dq_next  = {dq_reg[DUTY_W-2:0], ge};
                    rem_next = rem_step;
                end
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!ovalid_reg || out_pop)
                begin
                    if (favg_reg == '0)
                    begin
                        favg_next = quo_reg;
                        davg_next = dnew;
                    end
                    else
                    begin
                        favg_next = fsum[RATE_W:1];
                        davg_next = dsum[DUTY_W:1];
                    end
                    ofreq_next  = (favg_reg == '0) ? quo_reg : fsum[RATE_W:1];
                    oduty_next  = (favg_reg == '0) ? dnew : dsum[DUTY_W:1];
                    oto_next    = done_reg;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            dvd_reg    <= '0;
            rem_reg    <= '0;
            div_reg    <= '0;
            high_reg   <= '0;
            quo_reg    <= '0;
            dq_reg     <= '0;
            dfull_reg  <= 1'b0;
            done_reg   <= 1'b0;
            favg_reg   <= '0;
            davg_reg   <= '0;
            ovalid_reg <= 1'b0;
            ofreq_reg  <= '0;
            oduty_reg  <= '0;
            oto_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            dvd_reg    <= dvd_next;
            rem_reg    <= rem_next;
            div_reg    <= div_next;
            high_reg   <= high_next;
            quo_reg    <= quo_next;
            dq_reg     <= dq_next;
            dfull_reg  <= dfull_next;
            done_reg   <= done_next;
            favg_reg   <= favg_next;
            davg_reg   <= davg_next;
            ovalid_reg <= ovalid_next;
            ofreq_reg  <= ofreq_next;
            oduty_reg  <= oduty_next;
            oto_reg    <= oto_next;
        end
    end

endmodule

// File: rtl/core/pwm_input_capture_freq_duty.sv
// pwm input capture: one sampled pin level per item, frequency and duty per pwm period.
// the front end takes one tick item every clock cycle unless the queue is full, tracking
// the high time, the period and the elapsed ticks (all saturating COUNT_WIDTH-bit
// counters); each rising edge that closes a period, and each clear item, goes into a
// four-entry queue. the back end pops one queued item at a time; for a closed period its
// 32 frequency quotient bits and 8 duty bits pass one shared restoring divider step, then
// the averaging and the result register write follow once the output register is free.
// full rises only when the queue holds four items, so ticks are taken back to back as
// long as the pwm period outlasts the back end's per-period work on average; shorter
// periods stall the input side. results sit in a one-entry output register, popped in
// order. after the result flagged timed_out the block ignores ticks until reset; clear
// items still apply. configuration writes are expected only while the block is idle.
module pwm_input_capture_freq_duty #(
    parameter int COUNT_WIDTH = pwmc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input side
    input  logic                          push,
    output logic                          full,
    input  logic                          operation,
    input  logic                          pin_level,
    // result side
    output logic                          empty,
    input  logic                          pop,
    output logic [pwmc_pkg::RATE_W-1:0]   frequency,
    output logic [pwmc_pkg::DUTY_W-1:0]   duty,
    output logic                          timed_out,
    // configuration
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [pwmc_pkg::CFG_W-1:0]    cfg_data
);
    import pwmc_pkg::*;

    localparam int CTL_W = $bits(pwmc_ctl_t);
    localparam int Q_W   = CTL_W + 2 * COUNT_WIDTH;

    // configuration registers
    logic [RATE_W-1:0]    tick_rate_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // front to queue
    logic                   in_valid;
    logic                   q_push;
    pwmc_ctl_t              q_ctl_in;
    logic [COUNT_WIDTH-1:0] q_high_in;
    logic [COUNT_WIDTH-1:0] q_period_in;

    // queue to back
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;
    logic [Q_W-1:0]         q_rd_data;
    pwmc_ctl_t              q_ctl_out;
    logic [COUNT_WIDTH-1:0] q_high_out;
    logic [COUNT_WIDTH-1:0] q_period_out;
    logic                   out_valid;

    assign in_valid = push && !full;
    assign full     = q_full;
    assign empty    = !out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg <= RATE_W'(1000000);
            timeout_reg   <= TIMEOUT_W'(1000000);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TICK_RATE: tick_rate_reg <= cfg_data[RATE_W-1:0];
                CFG_TIMEOUT:   timeout_reg   <= cfg_data[TIMEOUT_W-1:0];
                default:       tick_rate_reg <= tick_rate_reg;
            endcase
        end
    end

    // tick counting and period detection
    pwmc_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .operation    (operation),
        .pin_level    (pin_level),
        .timeout_ticks(timeout_reg),
        .q_push       (q_push),
        .q_ctl        (q_ctl_in),
        .q_high       (q_high_in),
        .q_period     (q_period_in)
    );

    // decouples the per-tick front from the multi-cycle divider
    pwmc_fifo #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_data({q_ctl_in, q_high_in, q_period_in}),
        .rd_en  (q_pop),
        .rd_data(q_rd_data),
        .full   (q_full),
        .empty  (q_empty)
    );

    assign q_ctl_out    = q_rd_data[Q_W-1 -: CTL_W];
    assign q_high_out   = q_rd_data[2*COUNT_WIDTH-1 -: COUNT_WIDTH];
    assign q_period_out = q_rd_data[COUNT_WIDTH-1:0];

    // division, averaging and result register
    pwmc_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_rate_hz (tick_rate_reg),
        .q_empty      (q_empty),
        .q_ctl        (q_ctl_out),
        .q_high       (q_high_out),
        .q_period     (q_period_out),
        .q_pop        (q_pop),
        .out_pop      (pop),
        .out_valid    (out_valid),
        .out_frequency(frequency),
        .out_duty     (duty),
        .out_timed_out(timed_out)
    );

`ifndef SYNTHESIS
    // front never writes a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    // back never reads an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    // every accepted clear item reaches the queue
    a_clear_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && operation == OP_CLEAR) |-> (q_push && q_ctl_in.is_clear))
        else $error("clear item not queued");
`endif

endmodule
